@@ rtl/mss_pkg.sv @@
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the masked signature scanner
// Widths of the beat fields, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package mss_pkg;

  // Longest pattern the window can hold
  localparam int MAX_PATTERN_BYTES = 8;

  localparam int BYTE_W     = 8;
  localparam int PAT_W      = 64;
  localparam int LEN_W      = 4;
  localparam int COUNT_W    = 32;
  localparam int ADDR_W     = 64;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  // Index into the byte window
  localparam int WIN_IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  localparam logic [LEN_W-1:0]   MAX_LEN   = LEN_W'(MAX_PATTERN_BYTES);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_VALUE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MASK   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE    = CFG_IDX_W'(3);

  // Configuration as seen by the scan core
  typedef struct packed {
    logic [PAT_W-1:0]  pattern_value;
    logic [PAT_W-1:0]  pattern_mask;
    logic [LEN_W-1:0]  pattern_length;
    logic [ADDR_W-1:0] region_base;
  } cfg_t;

  // One held input beat
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } beat_t;

endpackage

@@ rtl/mss_in_if.sv @@
// ----------------------------------------------------------------------------
// mss_in_if: region byte channel
// One beat carries one byte of the scanned region and its last flag.
// ----------------------------------------------------------------------------
interface mss_in_if;
  logic                      valid;
  logic                      ready;
  logic [mss_pkg::BYTE_W-1:0] data_byte;
  logic                      last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/mss_out_if.sv @@
// ----------------------------------------------------------------------------
// mss_out_if: scan result channel
// One beat per region outcome: a match position or a not-found report.
// ----------------------------------------------------------------------------
interface mss_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [mss_pkg::COUNT_W-1:0] match_offset;
  logic [mss_pkg::ADDR_W-1:0]  match_address;

  modport source (output valid, output found, output match_offset,
                  output match_address, input ready);
  modport sink   (input valid, input found, input match_offset,
                  input match_address, output ready);
endinterface

@@ rtl/mss_cfg_if.sv @@
// ----------------------------------------------------------------------------
// mss_cfg_if: configuration write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface mss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mss_pkg::CFG_IDX_W-1:0]  index;
  logic [mss_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mss_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mss_cfg_regs: configuration register file
// Pattern value, care mask, length and region base; unknown indexes ignored.
// ----------------------------------------------------------------------------
module mss_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  mss_cfg_if.sink         cfg,
  output mss_pkg::cfg_t   regs
);
  import mss_pkg::*;

  // Writes always complete in one beat
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PATTERN_VALUE:  regs.pattern_value  <= cfg.data;
        REG_PATTERN_MASK:   regs.pattern_mask   <= cfg.data;
        REG_PATTERN_LENGTH: regs.pattern_length <= cfg.data[LEN_W-1:0];
        REG_REGION_BASE:    regs.region_base    <= cfg.data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/mss_scan_core.sv @@
// ----------------------------------------------------------------------------
// mss_scan_core: window compare and result register
// Shifts the held byte into the window, compares the masked pattern, keeps
// the region byte count and loads the result register.
// ----------------------------------------------------------------------------
module mss_scan_core (
  input  logic            clk,
  input  logic            rst,
  input  mss_pkg::cfg_t   regs,
  input  logic            beat_valid,
  input  mss_pkg::beat_t  beat,
  output logic            take,
  mss_out_if.source       result
);
  import mss_pkg::*;

  logic [BYTE_W-1:0]  win [MAX_PATTERN_BYTES];
  logic [BYTE_W-1:0]  win_next [MAX_PATTERN_BYTES];
  logic [COUNT_W-1:0] bytes_seen;
  logic [COUNT_W-1:0] bytes_seen_next;
  logic               scan_done;

  logic [LEN_W-1:0]   len_eff;
  logic               may_check;
  logic               window_ok;
  logic               hit;
  logic               produce;
  logic [COUNT_W-1:0] offset;
  logic               out_free;

  // Pipeline moves when the result register is free or being drained
  assign out_free = !result.valid || result.ready;
  assign take     = beat_valid && out_free;

  // New window: held byte in front, older bytes move back one place
  always_comb begin
    win_next[0] = beat.data_byte;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      win_next[k] = win[k-1];
    end
  end

  assign len_eff = (regs.pattern_length > MAX_LEN) ? MAX_LEN : regs.pattern_length;

  // Masked compare of every pattern byte against its window position
  always_comb begin : match_logic
    logic [WIN_IDX_W-1:0] pos;
    logic [BYTE_W-1:0]    want;
    logic [BYTE_W-1:0]    care;
    window_ok = 1'b1;
    pos       = '0;
    want      = '0;
    care      = '0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (LEN_W'(i) < len_eff) begin
        pos  = WIN_IDX_W'(len_eff - LEN_W'(i) - LEN_W'(1));
        want = regs.pattern_value[BYTE_W*i +: BYTE_W];
        care = regs.pattern_mask[BYTE_W*i +: BYTE_W];
        if (((win_next[pos] ^ want) & care) != '0) begin
          window_ok = 1'b0;
        end
      end
    end
  end

  // Saturating byte count, hit qualification and offset
  assign may_check       = (bytes_seen != COUNT_MAX);
  assign bytes_seen_next = may_check ? bytes_seen + COUNT_W'(1) : bytes_seen;
  assign hit     = may_check && (len_eff != '0) &&
                   (bytes_seen_next >= COUNT_W'(len_eff)) && window_ok;
  assign produce = !scan_done && (hit || beat.last_byte);
  assign offset  = bytes_seen_next - COUNT_W'(len_eff);

  // Scan state: clears at the end of every region
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        win[k] <= '0;
      end
      bytes_seen <= '0;
      scan_done  <= 1'b0;
    end else if (take) begin
      if (beat.last_byte) begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
          win[k] <= '0;
        end
        bytes_seen <= '0;
        scan_done  <= 1'b0;
      end else if (!scan_done) begin
        win        <= win_next;
        bytes_seen <= bytes_seen_next;
        scan_done  <= hit;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take && produce) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      result.found         <= hit;
      result.match_offset  <= hit ? offset : '0;
      result.match_address <= hit ? regs.region_base + ADDR_W'(offset) : '0;
    end
  end

  // A not-found beat carries zero position fields
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.found |-> result.match_offset == '0 &&
                                      result.match_address == '0)
    else $error("not-found result with nonzero position");

  // A match mid-region stops further checking
  a_hit_sets_done: assert property (@(posedge clk) disable iff (rst)
    take && !scan_done && hit && !beat.last_byte |=> scan_done)
    else $error("match did not close the region scan");

  // Count advances by one per scanned byte until saturation
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    take && !scan_done && !beat.last_byte && may_check
    |=> bytes_seen == $past(bytes_seen) + COUNT_W'(1))
    else $error("byte count did not advance");

  // Nothing new is loaded while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !take)
    else $error("beat consumed while result stalled");

endmodule

@@ rtl/masked_signature_scan.sv @@
// ----------------------------------------------------------------------------
// masked_signature_scan: streaming search for a masked byte signature
// Scans region bytes and reports the first masked pattern match position.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : register writes (0 value, 1 care mask, 2 length, 3 base), always
//            ready; write only while no scan beat is in flight.
//   scan   : one region byte per beat, last_byte marks the region end.
//   report : one beat per region: found with offset and base+offset, or
//            not-found (zeros) on the last byte. Bytes after a match are
//            dropped until the last byte, which then reports nothing.
//   Path: a taken byte waits in the input register, where the window compare
//   sees it; its result is loaded into the result register when the core takes it.
//   Throughput: one byte per cycle while the result register is free or drained;
//   the whole window compare sits between the input register and the result register.
//   Stall: when report is held, the result register keeps its beat, the
//   input register fills and scan.ready drops until the result is taken.
//   Reset: clears registers, window, byte count and both pipeline stages.
// ----------------------------------------------------------------------------
module masked_signature_scan (
  input  logic clk,
  input  logic rst,
  mss_cfg_if.sink   cfg,
  mss_in_if.sink    scan,
  mss_out_if.source report
);
  import mss_pkg::*;

  cfg_t  regs;
  beat_t held;
  logic  held_valid;
  logic  take;

  mss_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Input register: free when empty or when its beat moves on this cycle
  assign scan.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (scan.valid && scan.ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      held.data_byte <= scan.data_byte;
      held.last_byte <= scan.last_byte;
    end
  end

  mss_scan_core u_scan_core (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .beat_valid (held_valid),
    .beat       (held),
    .take       (take),
    .result     (report)
  );

endmodule

@@ dv/masked_signature_scan_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_signature_scan_tb: self-checking bench for the signature scanner
// Drives region bytes and register writes over valid/ready channels with
// random idle gaps and stalls on both sides. A behavioral scan model, fed
// each accepted byte, queues the expected report beats; every beat taken
// from the report channel is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module masked_signature_scan_tb;
  import mss_pkg::*;

  localparam int RANDOM_BYTES = 1400;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_REGION_BASE + CFG_IDX_W'(1);

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] offset;
    logic [ADDR_W-1:0]  address;
  } scan_report_t;

  localparam scan_report_t NOT_FOUND = '0;

  typedef enum {ROW_CFG, ROW_BYTE} row_kind_e;
  typedef enum {EXP_MODEL, EXP_NONE, EXP_GIVEN} exp_mode_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  wdata;
    logic [BYTE_W-1:0]      data;
    bit                     last;
    exp_mode_e              mode;
    scan_report_t           given;
  } stim_row_t;

  logic clk;
  logic rst;

  mss_cfg_if cfg_ch ();
  mss_in_if  scan_ch ();
  mss_out_if rpt_ch ();

  masked_signature_scan uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .scan   (scan_ch),
    .report (rpt_ch)
  );

  // Scan model state and its copy of the registers
  logic [PAT_W-1:0]   sig_value = '0;
  logic [PAT_W-1:0]   sig_care  = '0;
  logic [LEN_W-1:0]   sig_len   = '0;
  logic [ADDR_W-1:0]  base_addr = '0;
  logic [BYTE_W-1:0]  shift_win [MAX_PATTERN_BYTES];
  logic [COUNT_W-1:0] seen_cnt = '0;
  bit                 hit_latched = 1'b0;

  scan_report_t pending_reports[$];
  stim_row_t    directed_rows[$];

  int  errors      = 0;
  int  bytes_sent  = 0;
  int  live_bytes  = 0;
  int  reports_in  = 0;
  int  found_in    = 0;
  int  setups      = 0;
  int  cycles      = 0;
  bit  fast_mode   = 1'b0;
  bit  long_hold   = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles,
               pending_reports.size());
      $display("masked_signature_scan_tb: errors");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    errors++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  function automatic int idle_cycles();
    return fast_mode ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic int used_len();
    return (sig_len > MAX_LEN) ? MAX_PATTERN_BYTES : int'(sig_len);
  endfunction

  // Model: shift in one byte, return the report it causes, if any
  task automatic predict_scan_report(input logic [BYTE_W-1:0] data, input bit last,
                                     output bit made, output scan_report_t rep,
                                     output bit live);
    int                 eff;
    bit                 counting;
    bit                 hit;
    logic [COUNT_W-1:0] off;
    made = 1'b0;
    rep  = NOT_FOUND;
    live = !hit_latched;
    eff  = used_len();
    if (!hit_latched) begin
      counting = (seen_cnt != COUNT_MAX);
      for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) shift_win[i] = shift_win[i-1];
      shift_win[0] = data;
      if (counting) seen_cnt++;
      hit = counting && eff != 0 && seen_cnt >= eff;
      // pattern byte 0 lines up with the oldest byte of the window
      for (int i = 0; i < eff; i++) begin
        if (((shift_win[eff-1-i] ^ sig_value[8*i +: 8]) & sig_care[8*i +: 8]) != 0)
          hit = 1'b0;
      end
      if (hit) begin
        off         = seen_cnt - eff;
        rep.found   = 1'b1;
        rep.offset  = off;
        rep.address = base_addr + ADDR_W'(off);
        hit_latched = 1'b1;
        made        = 1'b1;
      end else if (last) begin
        made = 1'b1;
      end
    end
    if (last) begin
      foreach (shift_win[i]) shift_win[i] = '0;
      seen_cnt    = '0;
      hit_latched = 1'b0;
    end
  endtask

  // One register write; the model picks it up at the accepting edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] wdata);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= wdata;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_PATTERN_VALUE:  sig_value = wdata;
      REG_PATTERN_MASK:   sig_care  = wdata;
      REG_PATTERN_LENGTH: sig_len   = wdata[LEN_W-1:0];
      REG_REGION_BASE:    base_addr = wdata;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offer one byte after a random gap and queue what it should produce
  task automatic put_byte(input logic [BYTE_W-1:0] data, input bit last,
                          input exp_mode_e mode, input scan_report_t given);
    int           gap;
    bit           made;
    bit           live;
    scan_report_t rep;
    gap = idle_cycles();
    repeat (gap) begin
      @(negedge clk);
      scan_ch.valid <= 1'b0;
    end
    @(negedge clk);
    scan_ch.valid     <= 1'b1;
    scan_ch.data_byte <= data;
    scan_ch.last_byte <= last;
    do @(posedge clk); while (!scan_ch.ready);
    predict_scan_report(data, last, made, rep, live);
    bytes_sent++;
    if (live) live_bytes++;
    case (mode)
      EXP_MODEL: if (made) pending_reports = {pending_reports, rep};
      EXP_GIVEN: pending_reports = {pending_reports, given};
      default: ;
    endcase
  endtask

  // Stop offering and let every queued report drain out
  task automatic wait_quiet();
    @(negedge clk);
    scan_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] wdata);
    stim_row_t row;
    row       = '{kind: ROW_CFG, mode: EXP_NONE, default: '0};
    row.idx   = idx;
    row.wdata = wdata;
    directed_rows = {directed_rows, row};
  endtask

  task automatic add_byte(input logic [BYTE_W-1:0] data, input bit last,
                          input exp_mode_e mode, input scan_report_t given);
    stim_row_t row;
    row       = '{kind: ROW_BYTE, mode: EXP_NONE, default: '0};
    row.data  = data;
    row.last  = last;
    row.mode  = mode;
    row.given = given;
    directed_rows = {directed_rows, row};
  endtask

  // Random register setting, extremes weighted in
  task automatic pick_setting();
    logic [PAT_W-1:0] care;
    int               style;
    style = $urandom_range(0, 3);
    case (style)
      0: care = '1;
      1: care = '0;
      2: begin
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
          case ($urandom_range(0, 3))
            0: care[8*i +: 8] = 8'hFF;
            1: care[8*i +: 8] = 8'hF0;
            2: care[8*i +: 8] = 8'h0F;
            default: care[8*i +: 8] = 8'h00;
          endcase
        end
      end
      default: care = {$urandom, $urandom};
    endcase
    write_reg(REG_PATTERN_VALUE, {$urandom, $urandom});
    write_reg(REG_PATTERN_MASK, care);
    case ($urandom_range(0, 7))
      0: write_reg(REG_PATTERN_LENGTH, '0);
      1: write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'($urandom_range(9, 15)));
      2: write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(MAX_PATTERN_BYTES));
      default: write_reg(REG_PATTERN_LENGTH,
                         CFG_DATA_W'($urandom_range(1, MAX_PATTERN_BYTES)));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(REG_REGION_BASE, '0);
      1: write_reg(REG_REGION_BASE, '1);
      default: write_reg(REG_REGION_BASE, {$urandom, $urandom});
    endcase
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_UNMAPPED), (1 << CFG_IDX_W) - 1)),
                {$urandom, $urandom});
    setups++;
  endtask

  // Random region, optionally carrying the pattern with random wildcard bits
  task automatic run_region(input int n, input bit embed, input bit corrupt,
                            input bit close);
    logic [BYTE_W-1:0] region_data[$];
    logic [BYTE_W-1:0] care;
    int                eff;
    int                at;
    eff = used_len();
    for (int i = 0; i < n; i++) region_data = {region_data, BYTE_W'($urandom)};
    if (embed && eff != 0 && eff <= n) begin
      at = $urandom_range(0, n - eff);
      for (int j = 0; j < eff; j++) begin
        care = sig_care[8*j +: 8];
        region_data[at+j] = (sig_value[8*j +: 8] & care) | (BYTE_W'($urandom) & ~care);
      end
      // near miss: break one cared bit of the final pattern byte
      if (corrupt) region_data[at+eff-1] ^= care & -care;
    end
    for (int i = 0; i < n; i++)
      put_byte(region_data[i], close && i == n - 1, EXP_MODEL, NOT_FOUND);
  endtask

  // Report side: random ready gaps, one long hold on request, checking
  initial begin
    scan_report_t want;
    int           wait_n;
    rpt_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        @(negedge clk);
        rpt_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_n = idle_cycles();
      repeat (wait_n) begin
        @(negedge clk);
        rpt_ch.ready <= 1'b0;
      end
      @(negedge clk);
      rpt_ch.ready <= 1'b1;
      do @(posedge clk); while (!rpt_ch.valid);
      reports_in++;
      if (rpt_ch.found) found_in++;
      if (pending_reports.size() == 0) begin
        flag_error($sformatf("report with nothing pending: found=%0d off=%0d addr=%h",
                             rpt_ch.found, rpt_ch.match_offset, rpt_ch.match_address));
      end else begin
        want = pending_reports.pop_front();
        if (rpt_ch.found !== want.found)
          flag_error($sformatf("found %0d, want %0d", rpt_ch.found, want.found));
        if (rpt_ch.match_offset !== want.offset)
          flag_error($sformatf("match_offset %0d, want %0d", rpt_ch.match_offset,
                               want.offset));
        if (rpt_ch.match_address !== want.address)
          flag_error($sformatf("match_address %h, want %h", rpt_ch.match_address,
                               want.address));
      end
    end
  end

  // Main sequence
  initial begin
    int target;
    int phase;
    int regions;
    int n;
    bit close;
    foreach (shift_win[i]) shift_win[i] = '0;
    rst               = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    scan_ch.valid     = 1'b0;
    scan_ch.data_byte = '0;
    scan_ch.last_byte = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    // registers still at reset: zero length never matches
    add_byte(8'h00, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'hFF, 1'b1, EXP_GIVEN, NOT_FOUND);
    // two byte pattern AB CD, full care, base at the top of the address space
    add_cfg(REG_PATTERN_VALUE, 64'h0000_0000_0000_CDAB);
    add_cfg(REG_PATTERN_MASK, '1);
    add_cfg(REG_PATTERN_LENGTH, 64'd2);
    add_cfg(REG_REGION_BASE, '1);
    // match at offset 1, address wraps to zero; later bytes and the
    // closing byte stay silent
    add_byte(8'h11, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'hAB, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'hCD, 1'b0, EXP_GIVEN, '{1'b1, 32'd1, 64'd0});
    add_byte(8'hAB, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'hCD, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'h00, 1'b1, EXP_NONE, NOT_FOUND);
    // write to an unmapped index must change nothing
    add_cfg(REG_UNMAPPED, '0);
    // match on the closing byte
    add_byte(8'hAB, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'hCD, 1'b1, EXP_GIVEN, '{1'b1, 32'd0, '1});
    // reversed order: not found
    add_byte(8'hCD, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'hAB, 1'b1, EXP_GIVEN, NOT_FOUND);
    // region shorter than the pattern
    add_byte(8'hAB, 1'b1, EXP_GIVEN, NOT_FOUND);
    // length above the window clamps to eight; high nibbles cared only
    add_cfg(REG_PATTERN_LENGTH, 64'd15);
    add_cfg(REG_PATTERN_VALUE, 64'h8877_6655_4433_2211);
    add_cfg(REG_PATTERN_MASK, 64'hF0F0_F0F0_F0F0_F0F0);
    add_cfg(REG_REGION_BASE, '0);
    add_byte(8'h1F, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'h2E, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'h3D, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'h4C, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'h5B, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'h6A, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'h79, 1'b0, EXP_NONE, NOT_FOUND);
    add_byte(8'h8F, 1'b1, EXP_GIVEN, '{1'b1, 32'd0, 64'd0});
    // all wildcard, one byte: the first byte matches
    add_cfg(REG_PATTERN_MASK, '0);
    add_cfg(REG_PATTERN_LENGTH, 64'd1);
    add_byte(8'h5A, 1'b0, EXP_GIVEN, '{1'b1, 32'd0, 64'd0});
    add_byte(8'h00, 1'b1, EXP_NONE, NOT_FOUND);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_quiet();
        write_reg(directed_rows[i].idx, directed_rows[i].wdata);
      end else begin
        put_byte(directed_rows[i].data, directed_rows[i].last,
                 directed_rows[i].mode, directed_rows[i].given);
      end
    end

    // Random phases: new setting, then a handful of regions
    target = bytes_sent + RANDOM_BYTES;
    phase  = 0;
    while (bytes_sent < target) begin
      wait_quiet();
      pick_setting();
      fast_mode = ($urandom_range(0, 4) == 0);
      if (phase == 2 || phase == 9) long_hold = 1'b1;
      regions = $urandom_range(2, 6);
      for (int r = 0; r < regions; r++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
        // now and then leave the region open across the next setting
        close = !(r == regions - 1 && $urandom_range(0, 3) == 0);
        run_region(n, $urandom_range(0, 9) < 7, $urandom_range(0, 5) == 0, close);
      end
      phase++;
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    $display("covered %0d bytes (%0d scanned), %0d register setups, %0d phases",
             bytes_sent, live_bytes, setups, phase);
    $display("took %0d reports, %0d of them matches, %0d mismatches",
             reports_in, found_in, errors);
    if (errors == 0) begin
      $display("masked_signature_scan_tb: clean");
    end else begin
      $display("masked_signature_scan_tb: errors");
    end
    $finish;
  end

endmodule
